/* sv/ip_address_text_parser_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the address text parser
// Shared shorthand for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_PARSER_ASSERT_SVH
`define IP_ADDRESS_TEXT_PARSER_ASSERT_SVH

// checked outside reset
`define IPAP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IPAP_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/ipap_pkg.sv */
// ----------------------------------------------------------------------------
// ipap_pkg
// Shared types and codes of the IPv4 / IPv6 address text parser.
// ----------------------------------------------------------------------------
package ipap_pkg;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_V4   = 2'd1,
		MODE_V6   = 2'd2
	} ipap_mode_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_NO_SEP    = 3'd1,
		ERR_RANGE     = 3'd2,
		ERR_SHORT     = 3'd3,
		ERR_MULTI_CMP = 3'd4,
		ERR_TOO_MANY  = 3'd5,
		ERR_BAD_CHAR  = 3'd6
	} ipap_err_t;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam int          ADDR_W    = 128;
	localparam int          GROUPS    = 8;
	localparam logic [3:0]  GROUPS_N  = 4'd8;

	// parsed string, before '::' expansion
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [3:0]        gc;
		logic [3:0]        cp;
		logic              cs;
		ipap_mode_t        mode;
		ipap_err_t         err;
	} ipap_raw_t;

endpackage

/* sv/ipap_parse.sv */
// ----------------------------------------------------------------------------
// ipap_parse
// Input register, per-character parse state and end-of-string result stage.
// ----------------------------------------------------------------------------
module ipap_parse
	import ipap_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       raw_valid,
	input  logic       raw_ready,
	output ipap_raw_t  raw
);

	typedef struct packed {
		ipap_mode_t        mode;
		logic [8:0]        dec;
		logic              dec_letter;
		logic [15:0]       hex;
		logic [2:0]        dc;
		logic [3:0]        gc;
		logic [ADDR_W-1:0] addr;
		logic [3:0]        cp;
		logic              cs;
		logic              pc;
		ipap_err_t         err;
	} ipap_state_t;

	function automatic ipap_err_t fail(ipap_err_t e, ipap_err_t code);
		return (e == ERR_NONE) ? code : e;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_0 && c <= CH_9)
			r = {1'b1, 4'(c - CH_0)};
		else if (c >= CH_LA && c <= CH_LF)
			r = {1'b1, 4'(c - CH_LA + 8'd10)};
		else if (c >= CH_UA && c <= CH_UF)
			r = {1'b1, 4'(c - CH_UA + 8'd10)};
		return r;
	endfunction

	function automatic ipap_state_t clear_group(ipap_state_t st);
		st.dec = '0;
		st.dec_letter = 1'b0;
		st.hex = '0;
		st.dc = '0;
		return st;
	endfunction

	function automatic ipap_state_t dec_add(ipap_state_t st, logic [3:0] d);
		logic [12:0] t;
		t = {4'd0, st.dec} * 13'd10 + {9'd0, d};
		st.dec = (t > 13'd256) ? 9'd256 : t[8:0];
		if (st.dc != 3'd7)
			st.dc = st.dc + 3'd1;
		return st;
	endfunction

	function automatic ipap_state_t v4_group_end(ipap_state_t st);
		if (st.dec_letter)
			st.err = fail(st.err, ERR_BAD_CHAR);
		else if (st.dc == 3'd0 || st.dc > 3'd4 || st.dec > 9'd255)
			st.err = fail(st.err, ERR_RANGE);
		else if (st.gc >= 4'd4)
			st.err = fail(st.err, ERR_TOO_MANY);
		else begin
			st.addr[63:0] = {32'd0, st.addr[23:0], st.dec[7:0]};
			st.gc = st.gc + 4'd1;
		end
		return clear_group(st);
	endfunction

	function automatic ipap_state_t v6_commit(ipap_state_t st);
		if (st.dc > 3'd4)
			st.err = fail(st.err, ERR_RANGE);
		else if (st.gc >= GROUPS_N || (st.cs && st.gc >= 4'd7))
			st.err = fail(st.err, ERR_TOO_MANY);
		else begin
			for (int i = 0; i < GROUPS; i++)
				if (st.gc[2:0] == 3'(i))
					st.addr[ADDR_W-1-16*i -: 16] = st.hex;
			st.gc = st.gc + 4'd1;
		end
		return clear_group(st);
	endfunction

	function automatic ipap_state_t v6_colon(ipap_state_t st);
		if (st.dc != 3'd0)
			st = v6_commit(st);
		else if (st.pc) begin
			if (st.cs)
				st.err = fail(st.err, ERR_MULTI_CMP);
			else if (st.gc >= GROUPS_N)
				st.err = fail(st.err, ERR_TOO_MANY);
			else begin
				st.cs = 1'b1;
				st.cp = st.gc;
			end
		end
		st.pc = 1'b1;
		return st;
	endfunction

	function automatic ipap_state_t take_char(ipap_state_t st, logic [7:0] c);
		logic [4:0] hv;
		hv = hex_val(c);
		unique case (st.mode)
			MODE_NONE: begin
				if (c == CH_DOT) begin
					st.mode = MODE_V4;
					st = v4_group_end(st);
				end else if (c == CH_COLON) begin
					st.mode = MODE_V6;
					st = v6_colon(st);
				end else if (hv[4]) begin
					// first group: track both readings until the separator shows
					st.hex = {st.hex[11:0], hv[3:0]};
					if (hv[3:0] > 4'd9) begin
						st.dec_letter = 1'b1;
						if (st.dc != 3'd7)
							st.dc = st.dc + 3'd1;
					end else if (!st.dec_letter)
						st = dec_add(st, hv[3:0]);
					else if (st.dc != 3'd7)
						st.dc = st.dc + 3'd1;
				end else
					st.err = fail(st.err, ERR_BAD_CHAR);
			end
			MODE_V4: begin
				if (c == CH_DOT)
					st = v4_group_end(st);
				else if (c >= CH_0 && c <= CH_9)
					st = dec_add(st, hv[3:0]);
				else
					st.err = fail(st.err, ERR_BAD_CHAR);
			end
			MODE_V6: begin
				if (c == CH_COLON)
					st = v6_colon(st);
				else if (hv[4]) begin
					// lone leading colon, or fifth digit
					if ((st.pc && st.gc == 4'd0 && !st.cs) || st.dc >= 3'd4)
						st.err = fail(st.err, ERR_RANGE);
					else begin
						st.hex = {st.hex[11:0], hv[3:0]};
						st.dc = st.dc + 3'd1;
					end
					st.pc = 1'b0;
				end else
					st.err = fail(st.err, ERR_BAD_CHAR);
			end
			default: st.err = fail(st.err, ERR_BAD_CHAR);
		endcase
		return st;
	endfunction

	function automatic ipap_state_t finish(ipap_state_t st);
		unique case (st.mode)
			MODE_NONE: st.err = fail(st.err, ERR_NO_SEP);
			MODE_V4: begin
				st = v4_group_end(st);
				if (st.err == ERR_NONE && st.gc < 4'd4)
					st.err = fail(st.err, ERR_SHORT);
			end
			MODE_V6: begin
				if (st.dc != 3'd0)
					st = v6_commit(st);
				else if (st.pc && !(st.cs && st.cp == st.gc))
					st.err = fail(st.err, ERR_RANGE);
				if (st.err == ERR_NONE && !st.cs && st.gc < GROUPS_N)
					st.err = fail(st.err, ERR_SHORT);
			end
			default: st.err = fail(st.err, ERR_NO_SEP);
		endcase
		return st;
	endfunction

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	ipap_state_t state_q;
	ipap_state_t state_nxt;
	logic        raw_valid_s2;
	ipap_raw_t   raw_s2;
	logic        s2_ready;
	logic        go;

	assign s2_ready = !raw_valid_s2 || raw_ready;
	assign go       = valid_s1 && (!last_s1 || s2_ready);
	assign in_ready = !valid_s1 || go;

	always_comb begin
		state_nxt = state_q;
		if (state_nxt.err == ERR_NONE)
			state_nxt = take_char(state_nxt, char_s1);
		if (last_s1 && state_nxt.err == ERR_NONE)
			state_nxt = finish(state_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			raw_valid_s2 <= 1'b0;
			state_q      <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (go) begin
				if (last_s1) begin
					state_q      <= '0;
					raw_valid_s2 <= 1'b1;
				end else begin
					state_q <= state_nxt;
					if (raw_ready)
						raw_valid_s2 <= 1'b0;
				end
			end else if (raw_ready)
				raw_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
		if (go && last_s1) begin
			raw_s2.addr <= state_nxt.addr;
			raw_s2.gc   <= state_nxt.gc;
			raw_s2.cp   <= state_nxt.cp;
			raw_s2.cs   <= state_nxt.cs;
			raw_s2.mode <= state_nxt.mode;
			raw_s2.err  <= state_nxt.err;
		end
	end

	assign raw_valid = raw_valid_s2;
	assign raw       = raw_s2;

endmodule

/* sv/ipap_expand.sv */
// ----------------------------------------------------------------------------
// ipap_expand
// Expands '::' into zero groups, blanks errored results, holds the output word.
// ----------------------------------------------------------------------------
module ipap_expand
	import ipap_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              raw_valid,
	output logic              raw_ready,
	input  ipap_raw_t         raw,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] out_addr,
	output ipap_mode_t        out_mode,
	output ipap_err_t         out_err
);

	logic [15:0]       grp [GROUPS];
	logic [ADDR_W-1:0] addr_x;
	logic [3:0]        z;
	logic [4:0]        tail;
	logic              do_expand;
	logic              out_valid_q;
	logic [ADDR_W-1:0] addr_q;
	ipap_mode_t        mode_q;
	ipap_err_t         err_q;

	assign z         = GROUPS_N - raw.gc;
	assign tail      = {1'b0, raw.cp} + {1'b0, z};
	assign do_expand = raw.cs && raw.gc <= GROUPS_N && raw.cp <= raw.gc;

	always_comb begin
		for (int i = 0; i < GROUPS; i++)
			grp[i] = raw.addr[ADDR_W-1-16*i -: 16];
		addr_x = raw.addr;
		if (do_expand) begin
			for (int i = 0; i < GROUPS; i++) begin
				// groups after the gap move right by z, the gap reads zero
				if (5'(i) >= tail) begin
					addr_x[ADDR_W-1-16*i -: 16] = '0;
					for (int j = 0; j < GROUPS; j++)
						if ({1'b0, z} + 5'(j) == 5'(i))
							addr_x[ADDR_W-1-16*i -: 16] = grp[j];
				end else if (5'(i) >= {1'b0, raw.cp})
					addr_x[ADDR_W-1-16*i -: 16] = '0;
			end
		end
		if (raw.err != ERR_NONE)
			addr_x = '0;
	end

	assign raw_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (raw_ready)
			out_valid_q <= raw_valid;
	end

	always_ff @(posedge clk) begin
		if (raw_ready && raw_valid) begin
			addr_q <= addr_x;
			mode_q <= raw.mode;
			err_q  <= raw.err;
		end
	end

	assign out_valid = out_valid_q;
	assign out_addr  = addr_q;
	assign out_mode  = mode_q;
	assign out_err   = err_q;

endmodule

/* sv/ip_address_text_parser.sv */
// ----------------------------------------------------------------------------
// ip_address_text_parser
// IPv4 dotted decimal / IPv6 colon hex address text parser.
// ----------------------------------------------------------------------------
// Takes one character per cycle on the slave side; s_tlast marks the final
// character of a string. The first '.' or ':' picks IPv4 or IPv6. Each string
// gives one output word after its last character: the 128-bit big-endian
// address (IPv4 in the low 32 bits), the version and an error code; on error
// the address is zero. Characters stream back to back at one per cycle with
// no gap between strings; a result word passes from its last character
// through the input register, the parse result register, then '::'
// expansion into the output register. Only output backpressure stalls the
// input.
module ip_address_text_parser
	import ipap_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] char_code
	input  logic         s_tlast,   // last_char
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // [63:0] address_high, [127:64] address_low
	output logic [4:0]   m_tuser    // [1:0] ip_version, [4:2] error_code
);

	logic              raw_valid;
	logic              raw_ready;
	ipap_raw_t         raw;
	logic [ADDR_W-1:0] addr;
	ipap_mode_t        mode;
	ipap_err_t         err;

	ipap_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_char   (s_tdata),
		.in_last   (s_tlast),
		.raw_valid (raw_valid),
		.raw_ready (raw_ready),
		.raw       (raw)
	);

	ipap_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_ready (raw_ready),
		.raw       (raw),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_addr  (addr),
		.out_mode  (mode),
		.out_err   (err)
	);

	assign m_tdata = {addr[63:0], addr[127:64]};
	assign m_tuser = {err, mode};

endmodule

/* sv/ip_address_text_parser_checker.sv */
// ----------------------------------------------------------------------------
// ip_address_text_parser_checker
// Port-level checks of the address text parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ip_address_text_parser_assert.svh"

module ip_address_text_parser_checker
	import ipap_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [4:0]   m_tuser
);

	`IPAP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output word changed while stalled")
	`IPAP_ASSERT(a_err_zero_addr, m_tvalid && m_tuser[4:2] != ERR_NONE |-> m_tdata == '0, "errored word carries an address")
	`IPAP_ASSERT(a_codes, m_tvalid |-> m_tuser[4:2] <= ERR_BAD_CHAR && m_tuser[1:0] != 2'b11, "undefined version or error code")
	`IPAP_ASSERT(a_v4_width, m_tvalid && m_tuser[1:0] == MODE_V4 |-> m_tdata[63:0] == '0 && m_tdata[127:96] == '0, "IPv4 address above bit 31")
	`IPAP_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !m_tvalid, "output valid during reset")

endmodule

bind ip_address_text_parser ip_address_text_parser_checker u_checker (.*);
